### rtl/ptt_pkg.sv
`default_nettype none
package ptt_pkg;

	// Field widths fixed by the interface.
	localparam int TimeW   = 63;
	localparam int HandleW = 32;
	localparam int DefMaxTimers = 16;

	localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

	typedef enum logic [1:0] {
		OP_REG   = 2'd0,
		OP_UNREG = 2'd1,
		OP_TICK  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_REG    = 2'd0,
		KIND_UNREG  = 2'd1,
		KIND_EXPIRE = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [TimeW-1:0]   now_time;
		logic [TimeW-1:0]   due_time;
		logic [TimeW-1:0]   repeat_interval;
		logic [HandleW-1:0] timer_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [HandleW-1:0] result_handle;
		logic               ok;
		logic [TimeW-1:0]   earliest_due;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [HandleW-1:0] handle;
		logic [TimeW-1:0]   due;
		logic [TimeW-1:0]   interval;
	} entry_t;

endpackage
`default_nettype wire

### rtl/periodic_timer_table_top.sv
`default_nettype none
// Timer table. A register command answers in the cycle after it is taken
// and leaves busy low. Unregister and tick run a pass over the chain of
// timer cells that visits each stored timer once; each expired periodic
// timer also waits on the remainder unit that advances its deadline
// (one bit a cycle); a closing result ends the pass. Results come at most
// one per cycle on rsp, marked by strobe, and cannot be stalled; last marks
// the final result of a command, and busy drops in the cycle that shows it.
module periodic_timer_table_top
	import ptt_pkg::*;
#(
	parameter int MAX_TIMERS = DefMaxTimers
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t req,
	output logic      busy,
	output logic      strobe,
	output rsp_t      rsp
);

	localparam int CntW = $clog2(MAX_TIMERS + 1);
	localparam int IdxW = $clog2(MAX_TIMERS);

	state_t              state_q, state_d;
	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     rem_q;
	logic [HandleW-1:0]  next_handle_q;
	logic [1:0]          op_q;
	logic [TimeW-1:0]    now_q;
	logic [HandleW-1:0]  id_q;
	logic                found_q;
	logic                any_q;
	logic [TimeW-1:0]    min_q;
	logic                strobe_q;
	rsp_t                rsp_q;

	entry_t              cells [MAX_TIMERS];
	entry_t              head;
	entry_t              load_data;
	logic                shift, load, step, keep, emit, div_start, div_done;
	logic [IdxW-1:0]     load_idx;
	rsp_t                emit_d;
	logic                accept;
	logic [HandleW-1:0]  fresh;
	logic [TimeW-1:0]    div_rem;
	logic [TimeW:0]      adv_sum;
	logic [TimeW-1:0]    adv_due;

	assign accept = start && (state_q == ST_IDLE);
	assign head   = cells[0];
	assign fresh  = (next_handle_q == '0) ? HandleW'(1) : next_handle_q;

	// Chain of timer cells; the tail wraps to the head.
	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		ptt_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.load     (load && (load_idx == IdxW'(i))),
			.nbr      (cells[(i + 1) % MAX_TIMERS]),
			.load_data(load_data),
			.q        (cells[i])
		);
	end

	ptt_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(now_q - head.due),
		.divisor (head.interval),
		.done    (div_done),
		.rem     (div_rem)
	);

	// Next deadline past now: now - ((now - due) mod period) + period.
	always_comb begin
		adv_sum = {1'b0, now_q} - {1'b0, div_rem} + {1'b0, head.interval};
		adv_due = adv_sum[TimeW] ? TIME_MAX : adv_sum[TimeW-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.opcode == OP_UNREG || req.opcode == OP_TICK)) begin
					state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (step) begin
					state_d = (rem_q == CntW'(1)) ? ST_FINISH : ST_SCAN;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = (rem_q == CntW'(1)) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs: cell controls and the result beat of this cycle.
	always_comb begin
		shift     = 1'b0;
		load      = 1'b0;
		load_idx  = '0;
		load_data = head;
		step      = 1'b0;
		keep      = 1'b0;
		emit      = 1'b0;
		emit_d    = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.opcode == OP_REG) begin
					emit               = 1'b1;
					emit_d.result_kind = KIND_REG;
					emit_d.last        = 1'b1;
					if (count_q < CntW'(MAX_TIMERS)) begin
						load                 = 1'b1;
						load_idx             = count_q[IdxW-1:0];
						load_data.handle     = fresh;
						load_data.due        = (req.due_time == '0) ? req.now_time
						                                            : req.due_time;
						load_data.interval   = req.repeat_interval;
						emit_d.ok            = 1'b1;
						emit_d.result_handle = fresh;
					end
				end
			end
			ST_SCAN: begin
				if (op_q == OP_UNREG) begin
					step = 1'b1;
					keep = !(!found_q && id_q != '0 && head.handle == id_q);
				end else if (now_q >= head.due) begin
					emit                 = 1'b1;
					emit_d.result_kind   = KIND_EXPIRE;
					emit_d.result_handle = head.handle;
					emit_d.ok            = 1'b1;
					if (head.interval == '0) begin
						step = 1'b1;
					end else begin
						div_start = 1'b1;
					end
				end else begin
					step = 1'b1;
					keep = 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					step          = 1'b1;
					keep          = 1'b1;
					load_data.due = adv_due;
				end
			end
			ST_FINISH: begin
				emit        = 1'b1;
				emit_d.last = 1'b1;
				if (op_q == OP_UNREG) begin
					emit_d.result_kind = KIND_UNREG;
					emit_d.ok          = found_q;
				end else begin
					emit_d.result_kind  = KIND_DONE;
					emit_d.ok           = 1'b1;
					emit_d.earliest_due = any_q ? min_q : '0;
				end
			end
			default: ;
		endcase
		// A pass step pops the head; a kept entry goes back on the tail.
		if (step) begin
			shift = 1'b1;
			if (keep) begin
				load     = 1'b1;
				load_idx = IdxW'(count_q - 1'b1);
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			rem_q         <= '0;
			next_handle_q <= HandleW'(1);
			found_q       <= 1'b0;
			any_q         <= 1'b0;
			strobe_q      <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (accept) begin
				rem_q   <= count_q;
				found_q <= 1'b0;
				any_q   <= 1'b0;
				if (req.opcode == OP_REG && count_q < CntW'(MAX_TIMERS)) begin
					count_q       <= count_q + 1'b1;
					next_handle_q <= fresh + 1'b1;
				end
			end
			if (step) begin
				rem_q <= rem_q - 1'b1;
				if (!keep) begin
					count_q <= count_q - 1'b1;
					if (op_q == OP_UNREG) begin
						found_q <= 1'b1;
					end
				end else if (op_q == OP_TICK) begin
					any_q <= 1'b1;
				end
			end
		end
	end

	// Command fields, running minimum and the result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			now_q <= req.now_time;
			id_q  <= req.timer_handle;
		end
		if (step && keep && (!any_q || load_data.due < min_q)) begin
			min_q <= load_data.due;
		end
		if (emit) begin
			rsp_q <= emit_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MAX_TIMERS))
		else $error("timer count exceeds table size");
	a_rem_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= count_q || state_q == ST_IDLE)
		else $error("pass has more timers left than stored");
	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && rsp.last)
		else $error("pass ended without a final beat");
`endif

endmodule
`default_nettype wire

### rtl/ptt_cell.sv
`default_nettype none
// One timer slot of the chain: takes its right neighbor on a shift, or a
// fresh entry when it is the write target.
module ptt_cell
	import ptt_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   shift,
	input  wire logic   load,
	input  wire entry_t nbr,
	input  wire entry_t load_data,
	output entry_t      q
);

	entry_t entry_q;

	// Load wins over shift so that a kept entry lands on the chain tail.
	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_data;
		end else if (shift) begin
			entry_q <= nbr;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

### rtl/ptt_rem.sv
`default_nettype none
// Restoring remainder unit: one quotient bit per cycle.
module ptt_rem
	import ptt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [TimeW-1:0] dividend,
	input  wire logic [TimeW-1:0] divisor,
	output logic                  done,
	output logic [TimeW-1:0]      rem
);

	localparam int CntW = $clog2(TimeW);

	logic                busy_q;
	logic                done_q;
	logic [CntW-1:0]     cnt_q;
	logic [TimeW-1:0]    sh_q;
	logic [TimeW-1:0]    p_q;
	logic [TimeW-1:0]    r_q;
	logic [TimeW:0]      trial;
	logic [TimeW:0]      diff;

	// Shift the next dividend bit into the partial remainder.
	always_comb begin
		trial = {r_q, sh_q[TimeW-1]};
		diff  = trial - {1'b0, p_q};
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(TimeW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= dividend;
			p_q  <= divisor;
			r_q  <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[TimeW-2:0], 1'b0};
			r_q  <= (trial >= {1'b0, p_q}) ? diff[TimeW-1:0] : trial[TimeW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule
`default_nettype wire
